// File: rtl/dbt_pkg.sv
// Shared types and constants for the desktop-bus transceiver.
package dbt_pkg;

  localparam int QUEUE_DEPTH_DEF = 128;
  localparam int KEY_COUNT       = 128;
  localparam int ACC_WIDTH_DEF   = 16;

  localparam logic [7:0] NO_KEY     = 8'hFF;
  localparam logic [7:0] DUMMY_BYTE = 8'hFF;
  localparam logic [7:0] BTN_UP_BIT = 8'h80;

  localparam logic [3:0] KBD_ADDR_RST   = 4'd2;
  localparam logic [3:0] MOUSE_ADDR_RST = 4'd3;
  localparam logic [7:0] KBD_HDL_RST    = 8'd1;
  localparam logic [7:0] MOUSE_HDL_RST  = 8'd1;

  typedef enum logic [1:0] {
    REQ_BYTE  = 2'd0,
    REQ_LINE  = 2'd1,
    REQ_KEY   = 2'd2,
    REQ_MOUSE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    PH_CMD  = 2'd0,
    PH_EVEN = 2'd1,
    PH_ODD  = 2'd2,
    PH_IDLE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CMD_RESET  = 2'd0,
    CMD_FLUSH  = 2'd1,
    CMD_LISTEN = 2'd2,
    CMD_TALK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_KBD_ADDR   = 2'd0,
    CFG_MOUSE_ADDR = 2'd1,
    CFG_KBD_HDL    = 2'd2,
    CFG_MOUSE_HDL  = 2'd3
  } cfg_idx_t;

  localparam logic [1:0] REG_DATA = 2'd0;
  localparam logic [1:0] REG_ID   = 2'd3;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] reply_byte;
    logic       line_valid;
    logic       line_level;
  } res_t;

endpackage

// File: rtl/desktop_bus_transceiver_core.sv
// Desktop-bus transceiver with built-in keyboard and mouse: top level.
// Each accepted input word's result word is registered into a two-entry output buffer.
// Throughput: one input word per cycle while that buffer is not full; it keeps the input
// open while one result word waits.
// The key queue memory has registered reads of the two oldest entries, kept current
// every cycle with write bypass. Reset (synchronous, rst_n low) resets control state.
module desktop_bus_transceiver_core #(
  parameter int QUEUE_DEPTH = dbt_pkg::QUEUE_DEPTH_DEF,
  parameter int ACC_WIDTH   = dbt_pkg::ACC_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [7:0]        in_data_byte,
  input  logic [1:0]        in_line_state,
  input  logic [6:0]        in_key_code,
  input  logic              in_key_release,
  input  logic              in_button_pressed,
  input  logic signed [7:0] in_delta_x,
  input  logic signed [7:0] in_delta_y,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_byte_valid,
  output logic [7:0]        out_reply_byte,
  output logic              out_line_valid,
  output logic              out_line_level,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data
);

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int AW = ACC_WIDTH;
  localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};
  localparam logic signed [AW-1:0] ENC_HI  = AW'(63);
  localparam logic signed [AW-1:0] ENC_LO  = -(AW'(64));

  function automatic logic [QW-1:0] q_next(input logic [QW-1:0] i);
    q_next = (i == QW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] acc,
                                                   input logic signed [7:0] d);
    logic signed [AW:0] s;
    s = {acc[AW-1], acc} + {{(AW+1-8){d[7]}}, d};
    if (s[AW] != s[AW-1]) sat_add = s[AW] ? ACC_MIN : ACC_MAX;
    else sat_add = s[AW-1:0];
  endfunction

  function automatic logic [6:0] encode7(input logic signed [AW-1:0] v);
    if (v > ENC_HI) encode7 = 7'h3F;
    else if (v < ENC_LO) encode7 = 7'h40;
    else encode7 = v[6:0];
  endfunction

  // configuration defaults
  logic [3:0] cfg_kaddr_r, cfg_maddr_r;
  logic [7:0] cfg_khdl_r, cfg_mhdl_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_kaddr_r <= dbt_pkg::KBD_ADDR_RST;
      cfg_maddr_r <= dbt_pkg::MOUSE_ADDR_RST;
      cfg_khdl_r  <= dbt_pkg::KBD_HDL_RST;
      cfg_mhdl_r  <= dbt_pkg::MOUSE_HDL_RST;
    end else if (cfg_valid) begin
      case (dbt_pkg::cfg_idx_t'(cfg_index))
        dbt_pkg::CFG_KBD_ADDR:   cfg_kaddr_r <= cfg_data[3:0];
        dbt_pkg::CFG_MOUSE_ADDR: cfg_maddr_r <= cfg_data[3:0];
        dbt_pkg::CFG_KBD_HDL:    cfg_khdl_r  <= cfg_data;
        dbt_pkg::CFG_MOUSE_HDL:  cfg_mhdl_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // device and bus state
  dbt_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] rs0_r, rs0_nxt, rs1_r, rs1_nxt;
  logic [1:0] rcnt_r, rcnt_nxt, rpos_r, rpos_nxt;
  logic       larm_r, larm_nxt;
  logic [7:0] ls0_r, ls0_nxt;
  logic [1:0] lcnt_r, lcnt_nxt;
  logic [3:0] ltgt_r, ltgt_nxt;
  logic [1:0] lreg_r, lreg_nxt;
  logic [QW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [dbt_pkg::KEY_COUNT-1:0] held_r, held_nxt;
  logic signed [AW-1:0] adx_r, adx_nxt, ady_r, ady_nxt;
  logic       btn_r, btn_nxt;
  logic [3:0] kaddr_r, kaddr_nxt, maddr_r, maddr_nxt;
  logic [7:0] khdl_r, khdl_nxt, mhdl_r, mhdl_nxt;

  // key queue memory; rd0/rd1 always hold the entries at tail and tail+1
  logic [7:0] kq_mem [QUEUE_DEPTH];
  logic [7:0] rd0_r, rd1_r;
  logic       push_en;
  logic [7:0] push_byte;
  logic [QW-1:0] rd_a0, rd_a1;

  dbt_pkg::res_t res;
  logic accept;

  // output buffer
  dbt_pkg::res_t ob0_r, ob1_r;
  logic [1:0]    ocnt_r;
  logic          pop;

  assign in_ready = (ocnt_r != 2'd2);
  assign accept   = in_valid && in_ready;
  assign out_valid = (ocnt_r != 2'd0);
  assign pop      = out_valid && out_ready;
  assign out_byte_valid = ob0_r.byte_valid;
  assign out_reply_byte = ob0_r.reply_byte;
  assign out_line_valid = ob0_r.line_valid;
  assign out_line_level = ob0_r.line_level;

  logic [3:0] c_addr;
  logic [1:0] c_type, c_reg;
  logic       q_empty, key_ok, mv;
  logic [QW-1:0] t1, hn;

  assign c_addr  = in_data_byte[7:4];
  assign c_type  = in_data_byte[3:2];
  assign c_reg   = in_data_byte[1:0];
  assign q_empty = (head_r == tail_r);

  always_comb begin
    phase_nxt = phase_r;
    rs0_nxt = rs0_r; rs1_nxt = rs1_r;
    rcnt_nxt = rcnt_r; rpos_nxt = rpos_r;
    larm_nxt = larm_r; ls0_nxt = ls0_r; lcnt_nxt = lcnt_r;
    ltgt_nxt = ltgt_r; lreg_nxt = lreg_r;
    head_nxt = head_r; tail_nxt = tail_r;
    held_nxt = held_r;
    adx_nxt = adx_r; ady_nxt = ady_r; btn_nxt = btn_r;
    kaddr_nxt = kaddr_r; maddr_nxt = maddr_r;
    khdl_nxt = khdl_r; mhdl_nxt = mhdl_r;
    push_en = 1'b0;
    push_byte = {in_key_release, in_key_code};
    res = '0;
    t1 = q_next(tail_r);
    hn = q_next(head_r);
    key_ok = in_key_release ? held_r[in_key_code] : !held_r[in_key_code];
    mv = (in_delta_x != 8'sd0) || (in_delta_y != 8'sd0) || (in_button_pressed != btn_r);

    if (accept) begin
      case (dbt_pkg::req_t'(in_req_type))
        dbt_pkg::REQ_BYTE: begin
          if (larm_r) begin
            // listen data: first byte held, second byte completes the write
            if (lcnt_r == 2'd0) begin
              ls0_nxt = in_data_byte;
              lcnt_nxt = 2'd1;
            end else begin
              lcnt_nxt = 2'd2;
              larm_nxt = 1'b0;
              if (lreg_r == dbt_pkg::REG_ID) begin
                if (ltgt_r == kaddr_r) begin
                  kaddr_nxt = ls0_r[3:0];
                  khdl_nxt = in_data_byte;
                end else if (ltgt_r == maddr_r) begin
                  maddr_nxt = ls0_r[3:0];
                  mhdl_nxt = in_data_byte;
                end
              end
            end
          end else begin
            rcnt_nxt = 2'd0;
            rpos_nxt = 2'd0;
            case (dbt_pkg::cmd_t'(c_type))
              dbt_pkg::CMD_RESET: begin
                kaddr_nxt = cfg_kaddr_r; maddr_nxt = cfg_maddr_r;
                khdl_nxt = cfg_khdl_r; mhdl_nxt = cfg_mhdl_r;
                head_nxt = '0; tail_nxt = '0;
                held_nxt = '0;
                adx_nxt = '0; ady_nxt = '0; btn_nxt = 1'b0;
                larm_nxt = 1'b0; lcnt_nxt = 2'd0;
              end
              dbt_pkg::CMD_FLUSH: begin
                if (c_addr == kaddr_r) begin
                  head_nxt = '0; tail_nxt = '0;
                end else if (c_addr == maddr_r) begin
                  adx_nxt = '0; ady_nxt = '0;
                end
              end
              dbt_pkg::CMD_LISTEN: begin
                larm_nxt = 1'b1; lcnt_nxt = 2'd0;
                ltgt_nxt = c_addr; lreg_nxt = c_reg;
              end
              dbt_pkg::CMD_TALK: begin
                if (c_reg == dbt_pkg::REG_DATA && c_addr == kaddr_r) begin
                  rcnt_nxt = 2'd2;
                  if (q_empty) begin
                    rs0_nxt = dbt_pkg::NO_KEY; rs1_nxt = dbt_pkg::NO_KEY;
                  end else begin
                    rs0_nxt = rd0_r;
                    if (t1 == head_r) begin
                      rs1_nxt = dbt_pkg::NO_KEY;
                      tail_nxt = t1;
                    end else begin
                      rs1_nxt = rd1_r;
                      tail_nxt = q_next(t1);
                    end
                  end
                end else if (c_reg == dbt_pkg::REG_DATA && c_addr == maddr_r) begin
                  rcnt_nxt = 2'd2;
                  rs0_nxt = {!btn_r, encode7(ady_r)};
                  rs1_nxt = dbt_pkg::BTN_UP_BIT | {1'b0, encode7(adx_r)};
                  adx_nxt = '0; ady_nxt = '0;
                end else if (c_reg == dbt_pkg::REG_ID && c_addr == kaddr_r) begin
                  rcnt_nxt = 2'd2;
                  rs0_nxt = {4'd0, kaddr_r}; rs1_nxt = khdl_r;
                end else if (c_reg == dbt_pkg::REG_ID && c_addr == maddr_r) begin
                  rcnt_nxt = 2'd2;
                  rs0_nxt = {4'd0, maddr_r}; rs1_nxt = mhdl_r;
                end
              end
              default: ;
            endcase
          end
        end
        dbt_pkg::REQ_LINE: begin
          phase_nxt = dbt_pkg::phase_t'(in_line_state);
          case (dbt_pkg::phase_t'(in_line_state))
            dbt_pkg::PH_CMD: begin
              larm_nxt = 1'b0; lcnt_nxt = 2'd0;
            end
            dbt_pkg::PH_IDLE: begin
              res.line_valid = 1'b1;
              res.line_level = q_empty && (adx_r == '0) && (ady_r == '0);
            end
            default: begin
              if (!larm_r) begin
                res.byte_valid = 1'b1;
                res.line_valid = 1'b1;
                if (rpos_r < rcnt_r) begin
                  res.reply_byte = rpos_r[0] ? rs1_r : rs0_r;
                  res.line_level = 1'b1;
                  rpos_nxt = rpos_r + 2'd1;
                end else begin
                  res.reply_byte = dbt_pkg::DUMMY_BYTE;
                end
              end
            end
          endcase
        end
        dbt_pkg::REQ_KEY: begin
          if (key_ok) begin
            held_nxt[in_key_code] = !in_key_release;
            push_en = 1'b1;
            head_nxt = hn;
            // full: drop the oldest word
            if (hn == tail_r) tail_nxt = t1;
            if (phase_r == dbt_pkg::PH_IDLE) res.line_valid = 1'b1;
          end
        end
        dbt_pkg::REQ_MOUSE: begin
          btn_nxt = in_button_pressed;
          adx_nxt = sat_add(adx_r, in_delta_x);
          ady_nxt = sat_add(ady_r, in_delta_y);
          if (phase_r == dbt_pkg::PH_IDLE && mv) res.line_valid = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign rd_a0 = tail_nxt;
  assign rd_a1 = q_next(tail_nxt);

  always_ff @(posedge clk) begin
    if (push_en) kq_mem[head_r] <= push_byte;
  end

  always_ff @(posedge clk) begin
    rd0_r <= (push_en && head_r == rd_a0) ? push_byte : kq_mem[rd_a0];
    rd1_r <= (push_en && head_r == rd_a1) ? push_byte : kq_mem[rd_a1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dbt_pkg::PH_IDLE;
      rs0_r <= '0; rs1_r <= '0;
      rcnt_r <= '0; rpos_r <= '0;
      larm_r <= 1'b0; lcnt_r <= '0; ltgt_r <= '0; lreg_r <= '0;
      head_r <= '0; tail_r <= '0;
      held_r <= '0;
      adx_r <= '0; ady_r <= '0; btn_r <= 1'b0;
      kaddr_r <= dbt_pkg::KBD_ADDR_RST; maddr_r <= dbt_pkg::MOUSE_ADDR_RST;
      khdl_r <= dbt_pkg::KBD_HDL_RST; mhdl_r <= dbt_pkg::MOUSE_HDL_RST;
    end else begin
      phase_r <= phase_nxt;
      rs0_r <= rs0_nxt; rs1_r <= rs1_nxt;
      rcnt_r <= rcnt_nxt; rpos_r <= rpos_nxt;
      larm_r <= larm_nxt; lcnt_r <= lcnt_nxt; ltgt_r <= ltgt_nxt; lreg_r <= lreg_nxt;
      head_r <= head_nxt; tail_r <= tail_nxt;
      held_r <= held_nxt;
      adx_r <= adx_nxt; ady_r <= ady_nxt; btn_r <= btn_nxt;
      kaddr_r <= kaddr_nxt; maddr_r <= maddr_nxt;
      khdl_r <= khdl_nxt; mhdl_r <= mhdl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ls0_r <= ls0_nxt;
  end

  // output buffer: load on accept, advance on pop, hold otherwise
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= '0;
    end else begin
      ocnt_r <= ocnt_r + {1'b0, accept} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop && accept) begin
      ob0_r <= res;
    end else if (pop) begin
      ob0_r <= ob1_r;
    end else if (accept) begin
      if (ocnt_r == 2'd0) ob0_r <= res;
      else ob1_r <= res;
    end
  end

  a_ocnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r != 2'd3) else $error("output buffer count out of range");
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_reply_byte == 8'h00)
    else $error("reply byte set without byte_valid");
  a_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_line_valid |-> !out_line_level)
    else $error("line level set without line_valid");
  a_reply_pos: assert property (@(posedge clk) disable iff (!rst_n)
    rpos_r <= rcnt_r) else $error("reply position past reply count");

endmodule
